[hw/rtl/assert_macros.svh]
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on clk_i, off while rst_ni is low
`define LGP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Implication check: antecedent overlaps consequent
`define LGP_ASSERT_IMP(label, ante, cons, msg) \
  `LGP_ASSERT(label, (ante) |-> (cons), msg)

`endif

[hw/rtl/lgp_pkg.sv]
// Shared types, widths and command/status structs for the level partitioner
package lgp_pkg;

  localparam int unsigned MaxNodes      = 48;
  localparam int unsigned MaxLevels     = 32;
  localparam int unsigned MaxPartitions = 16;

  localparam int unsigned LevelW = 5;
  localparam int unsigned CostW  = 32;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned PartW  = 4;
  localparam int unsigned CntW   = 5;
  localparam int unsigned LoadW  = 38;
  localparam int unsigned SumW   = 44;
  localparam int unsigned ProdW  = SumW + CntW;

  localparam logic [IdxW-1:0] NodeCap     = IdxW'(MaxNodes);
  localparam logic [CntW-1:0] PartCountMax = CntW'(MaxPartitions);

  localparam logic KindAssign = 1'b0;
  localparam logic KindLoad   = 1'b1;

  typedef struct packed {
    logic [LevelW-1:0] node_level;
    logic [CostW-1:0]  node_cost;
    logic              last_node;
  } in_word_t;

  typedef struct packed {
    logic              result_kind;
    logic [IdxW-1:0]   item_index;
    logic [PartW-1:0]  assigned_partition;
    logic [LoadW-1:0]  partition_load;
    logic              node_overflow;
    logic              last_result;
  } out_word_t;

  typedef struct packed {
    logic load_node;
    logic walk_init;
    logic walk_sum;
    logic walk_step;
    logic node_emit;
    logic part_emit;
    logic run_clear;
  } cmd_t;

  typedef struct packed {
    logic last_level;
    logic node_none;
    logic last_node_out;
    logic last_part;
    logic out_free;
  } status_t;

endpackage

[hw/rtl/lgp_ctrl.sv]
// Sequencer: load, level walk, node emission, partition load emission
module lgp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  input  lgp_pkg::status_t status_i,
  output lgp_pkg::cmd_t   cmd_o,
  output logic            in_stall_o
);

  localparam logic [2:0] StLoad    = 3'd0;
  localparam logic [2:0] StWalkRd  = 3'd1;
  localparam logic [2:0] StWalkUpd = 3'd2;
  localparam logic [2:0] StNodeRd  = 3'd3;
  localparam logic [2:0] StNodeOut = 3'd4;
  localparam logic [2:0] StPartOut = 3'd5;

  logic [2:0] state_q, state_d;

  // Decode state into datapath commands and pick the next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      StLoad: begin
        cmd_o.load_node = in_valid_i;
        if (in_valid_i && in_last_i) begin
          cmd_o.walk_init = 1'b1;
          state_d = StWalkRd;
        end
      end
      StWalkRd: begin
        cmd_o.walk_sum = 1'b1;
        state_d = StWalkUpd;
      end
      StWalkUpd: begin
        cmd_o.walk_step = 1'b1;
        if (status_i.last_level) begin
          state_d = status_i.node_none ? StPartOut : StNodeRd;
        end else begin
          state_d = StWalkRd;
        end
      end
      StNodeRd: begin
        state_d = StNodeOut;
      end
      StNodeOut: begin
        if (status_i.out_free) begin
          cmd_o.node_emit = 1'b1;
          state_d = status_i.last_node_out ? StPartOut : StNodeRd;
        end
      end
      StPartOut: begin
        if (status_i.out_free) begin
          cmd_o.part_emit = 1'b1;
          if (status_i.last_part) begin
            cmd_o.run_clear = 1'b1;
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StLoad);

endmodule

[hw/rtl/lgp_dp.sv]
// Datapath: node store, level sums, walk arithmetic, output register
module lgp_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lgp_pkg::CntW-1:0]      cfg_data_i,
  input  lgp_pkg::in_word_t             in_word_i,
  input  lgp_pkg::cmd_t                 cmd_i,
  output lgp_pkg::status_t              status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output lgp_pkg::out_word_t            out_word_o
);

  // Node level memory, registered read
  logic [lgp_pkg::LevelW-1:0] node_mem [lgp_pkg::MaxNodes];
  logic [lgp_pkg::LevelW-1:0] node_rd_q;

  logic [lgp_pkg::LoadW-1:0]  lvl_sum_q    [lgp_pkg::MaxLevels];
  logic [lgp_pkg::PartW-1:0]  level_part_q [lgp_pkg::MaxLevels];
  logic [lgp_pkg::LoadW-1:0]  part_load_q  [lgp_pkg::MaxPartitions];

  logic [lgp_pkg::IdxW-1:0]   node_count_q;
  logic [lgp_pkg::LevelW-1:0] deepest_q;
  logic [lgp_pkg::LoadW-1:0]  total_q;
  logic                       overflow_q;
  logic [lgp_pkg::CntW-1:0]   part_count_q;

  logic [lgp_pkg::LevelW-1:0] d_q;
  logic [lgp_pkg::IdxW-1:0]   i_q;
  logic [lgp_pkg::PartW-1:0]  j_q;
  logic [lgp_pkg::PartW-1:0]  cur_q;
  logic [lgp_pkg::SumW-1:0]   load_q;
  logic [lgp_pkg::SumW-1:0]   sum_q;
  logic [lgp_pkg::LoadW-1:0]  lc_q;

  logic                       out_valid_q;
  lgp_pkg::out_word_t         out_word_q;

  logic [lgp_pkg::CntW-1:0]   n_eff;
  logic                       node_room;
  logic [lgp_pkg::LoadW-1:0]  lvl_cost_sel;
  logic [lgp_pkg::ProdW-1:0]  prod;
  logic [lgp_pkg::IdxW-1:0]   rem_levels;
  logic [lgp_pkg::IdxW-1:0]   rem_parts;
  logic                       advance;
  logic [lgp_pkg::PartW-1:0]  cur_next;
  logic [lgp_pkg::SumW-1:0]   load_next;
  logic [lgp_pkg::LevelW-1:0] cost_addr;

  // Clamp partition count into 1..MaxPartitions
  always_comb begin
    if (part_count_q == '0) begin
      n_eff = lgp_pkg::CntW'(1);
    end else if (part_count_q > lgp_pkg::PartCountMax) begin
      n_eff = lgp_pkg::PartCountMax;
    end else begin
      n_eff = part_count_q;
    end
  end

  assign node_room    = (node_count_q < lgp_pkg::NodeCap);
  assign cost_addr    = cmd_i.load_node ? in_word_i.node_level : d_q;
  assign lvl_cost_sel = lvl_sum_q[cost_addr];

  // Split decision for the level under the walk
  assign prod       = lgp_pkg::ProdW'(sum_q) * lgp_pkg::ProdW'(n_eff);
  assign rem_levels = lgp_pkg::IdxW'(deepest_q) + lgp_pkg::IdxW'(1) - lgp_pkg::IdxW'(d_q);
  assign rem_parts  = lgp_pkg::IdxW'(n_eff) - lgp_pkg::IdxW'(cur_q);
  assign advance    = ((lgp_pkg::CntW'(cur_q) + lgp_pkg::CntW'(1)) < n_eff)
                      && (load_q != '0)
                      && (prod > lgp_pkg::ProdW'(total_q))
                      && (rem_levels > rem_parts);
  assign cur_next   = advance ? cur_q + lgp_pkg::PartW'(1) : cur_q;
  assign load_next  = advance ? lgp_pkg::SumW'(lc_q) : sum_q;

  // Write the node memory and read it for emission
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_node && node_room) begin
      node_mem[node_count_q] <= in_word_i.node_level;
    end
    node_rd_q <= node_mem[i_q];
  end

  // Walk pipeline payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.walk_sum) begin
      lc_q  <= lvl_cost_sel;
      sum_q <= load_q + lgp_pkg::SumW'(lvl_cost_sel);
    end
  end

  // Accumulate, walk and clear the run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < lgp_pkg::MaxLevels; k++) begin
        lvl_sum_q[k]    <= '0;
        level_part_q[k] <= '0;
      end
      for (int k = 0; k < lgp_pkg::MaxPartitions; k++) begin
        part_load_q[k] <= '0;
      end
      node_count_q <= '0;
      deepest_q    <= '0;
      total_q      <= '0;
      overflow_q   <= 1'b0;
      part_count_q <= lgp_pkg::CntW'(1);
      d_q          <= '0;
      i_q          <= '0;
      j_q          <= '0;
      cur_q        <= '0;
      load_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        part_count_q <= cfg_data_i;
      end
      // Take one node
      if (cmd_i.load_node) begin
        if (node_room) begin
          node_count_q <= node_count_q + lgp_pkg::IdxW'(1);
          lvl_sum_q[in_word_i.node_level] <=
            lvl_cost_sel + lgp_pkg::LoadW'(in_word_i.node_cost);
          total_q <= total_q + lgp_pkg::LoadW'(in_word_i.node_cost);
          if (in_word_i.node_level > deepest_q) begin
            deepest_q <= in_word_i.node_level;
          end
        end else begin
          overflow_q <= 1'b1;
        end
      end
      if (cmd_i.walk_init) begin
        d_q    <= '0;
        i_q    <= '0;
        j_q    <= '0;
        cur_q  <= '0;
        load_q <= '0;
      end
      // Place one level
      if (cmd_i.walk_step) begin
        level_part_q[d_q] <= cur_next;
        cur_q  <= cur_next;
        load_q <= load_next;
        if (advance) begin
          part_load_q[cur_q] <= load_q[lgp_pkg::LoadW-1:0];
        end
        if (status_o.last_level) begin
          part_load_q[cur_next] <= load_next[lgp_pkg::LoadW-1:0];
        end else begin
          d_q <= d_q + lgp_pkg::LevelW'(1);
        end
      end
      if (cmd_i.node_emit) begin
        i_q <= i_q + lgp_pkg::IdxW'(1);
      end
      if (cmd_i.part_emit) begin
        j_q <= j_q + lgp_pkg::PartW'(1);
      end
      // Drop the run at its end
      if (cmd_i.run_clear) begin
        for (int k = 0; k < lgp_pkg::MaxLevels; k++) begin
          lvl_sum_q[k]    <= '0;
          level_part_q[k] <= '0;
        end
        for (int k = 0; k < lgp_pkg::MaxPartitions; k++) begin
          part_load_q[k] <= '0;
        end
        node_count_q <= '0;
        deepest_q    <= '0;
        total_q      <= '0;
        overflow_q   <= 1'b0;
      end
    end
  end

  // Output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.node_emit || cmd_i.part_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output word payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.node_emit) begin
      out_word_q.result_kind        <= lgp_pkg::KindAssign;
      out_word_q.item_index         <= i_q;
      out_word_q.assigned_partition <= level_part_q[node_rd_q];
      out_word_q.partition_load     <= '0;
      out_word_q.node_overflow      <= overflow_q;
      out_word_q.last_result        <= 1'b0;
    end else if (cmd_i.part_emit) begin
      out_word_q.result_kind        <= lgp_pkg::KindLoad;
      out_word_q.item_index         <= lgp_pkg::IdxW'(j_q);
      out_word_q.assigned_partition <= '0;
      out_word_q.partition_load     <= part_load_q[j_q];
      out_word_q.node_overflow      <= overflow_q;
      out_word_q.last_result        <= status_o.last_part;
    end
  end

  assign status_o.last_level    = (d_q == deepest_q);
  assign status_o.node_none     = (node_count_q == '0);
  assign status_o.last_node_out = ((i_q + lgp_pkg::IdxW'(1)) == node_count_q);
  assign status_o.last_part     = ((lgp_pkg::CntW'(j_q) + lgp_pkg::CntW'(1)) == n_eff);
  assign status_o.out_free      = !out_valid_q || !out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

[hw/rtl/level_greedy_partitioner.sv]
// Loading: one node word per cycle while in_stall_o is low; the last node
// starts the level walk. Walk: levels up to the deepest, each a sum step then a
// multiply-compare step. Emission: each node word takes a registered node memory
// read and an output state; partition loads follow, one per unstalled cycle.
// Reset (async, active low) clears all run state; partition count resets to 1.
module level_greedy_partitioner (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [lgp_pkg::CntW-1:0]  cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  lgp_pkg::in_word_t         in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output lgp_pkg::out_word_t        out_word_o
);

  lgp_pkg::cmd_t    cmd;
  lgp_pkg::status_t status;

  // Sequencer
  lgp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_word_i.last_node),
    .status_i   (status),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // Datapath
  lgp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

[hw/rtl/lgp_checker.sv]
// Port-level checks for the level partitioner, bound to the top level
`include "assert_macros.svh"

module lgp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input lgp_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input lgp_pkg::out_word_t out_word_o
);

  `LGP_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o, "output word dropped")
  `LGP_ASSERT(a_stall_after_last, in_valid_i && !in_stall_o && in_word_i.last_node |=> in_stall_o, "input open during run")
  `LGP_ASSERT_IMP(a_last_is_load, out_valid_o && out_word_o.last_result, out_word_o.result_kind == lgp_pkg::KindLoad, "last word not a load")
  `LGP_ASSERT_IMP(a_assign_zero_load, out_valid_o && out_word_o.result_kind == lgp_pkg::KindAssign, out_word_o.partition_load == '0, "assignment carries load")

endmodule

bind level_greedy_partitioner lgp_checker u_lgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);

[dv/testbench.sv]
// Self-checking testbench for the level greedy partitioner
module testbench;

  // Predicts and checks the node assignment and partition load words
  class partition_scoreboard;
    logic [4:0]  lvl_of_node[lgp_pkg::MaxNodes];
    logic [37:0] lvl_sum[lgp_pkg::MaxLevels];
    logic [37:0] part_load[lgp_pkg::MaxPartitions];
    logic [3:0]  level_part[lgp_pkg::MaxLevels];
    int unsigned n_nodes, deepest;
    logic [37:0] total;
    bit          dropped;
    logic [4:0]  part_count;
    lgp_pkg::out_word_t pending[$];
    int          errors;

    function void clear_run();
      foreach (lvl_sum[i]) lvl_sum[i] = '0;
      foreach (part_load[i]) part_load[i] = '0;
      foreach (level_part[i]) level_part[i] = '0;
      n_nodes = 0;
      deepest = 0;
      total = '0;
      dropped = 0;
    endfunction

    function new();
      clear_run();
      part_count = 5'd1;
      errors = 0;
    endfunction

    // Accumulate one accepted node; on the last node walk levels and queue words
    function void note_node(lgp_pkg::in_word_t w);
      int unsigned n, cur, d;
      logic [37:0] acc;
      logic [63:0] prod;
      lgp_pkg::out_word_t r;
      if (n_nodes < lgp_pkg::MaxNodes) begin
        lvl_of_node[n_nodes] = w.node_level;
        n_nodes++;
        lvl_sum[w.node_level] = lvl_sum[w.node_level] + w.node_cost;
        total = total + w.node_cost;
        if (w.node_level > deepest) deepest = w.node_level;
      end else begin
        dropped = 1;
      end
      if (!w.last_node) return;
      n = (part_count == 0) ? 1 :
          (part_count > lgp_pkg::MaxPartitions) ? lgp_pkg::MaxPartitions : part_count;
      cur = 0;
      acc = '0;
      for (d = 0; d <= deepest; d++) begin
        prod = (64'(acc) + 64'(lvl_sum[d])) * n;
        if (cur + 1 < n && acc != 0 && prod > 64'(total) &&
            (deepest + 1 - d) > (n - cur)) begin
          cur++;
          acc = '0;
        end
        level_part[d] = cur[3:0];
        part_load[cur] = part_load[cur] + lvl_sum[d];
        acc = acc + lvl_sum[d];
      end
      for (int i = 0; i < n_nodes; i++) begin
        r = '{lgp_pkg::KindAssign, 6'(i), level_part[lvl_of_node[i]], 38'd0, dropped, 1'b0};
        pending.push_back(r);
      end
      for (int i = 0; i < n; i++) begin
        r = '{lgp_pkg::KindLoad, 6'(i), 4'd0, part_load[i], dropped, 1'(i + 1 == n)};
        pending.push_back(r);
      end
      clear_run();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      $display("mismatch %s: got %0h want %0h", what, got, want);
    endtask

    // Compare one emitted word with the oldest expectation
    task check_word(lgp_pkg::out_word_t g);
      lgp_pkg::out_word_t e;
      if (pending.size() == 0) begin
        report("unexpected word", g, 0);
        return;
      end
      e = pending.pop_front();
      if (g.result_kind !== e.result_kind) report("kind", g.result_kind, e.result_kind);
      if (g.item_index !== e.item_index) report("index", g.item_index, e.item_index);
      if (g.assigned_partition !== e.assigned_partition)
        report("partition", g.assigned_partition, e.assigned_partition);
      if (g.partition_load !== e.partition_load)
        report("load", g.partition_load, e.partition_load);
      if (g.node_overflow !== e.node_overflow)
        report("overflow", g.node_overflow, e.node_overflow);
      if (g.last_result !== e.last_result) report("last", g.last_result, e.last_result);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [lgp_pkg::CntW-1:0] cfg_data = '0;
  logic in_valid = 0, out_stall = 0;
  logic in_stall, out_valid;
  lgp_pkg::in_word_t in_word = '0;
  lgp_pkg::out_word_t out_word;
  partition_scoreboard sb = new();
  int unsigned cycles = 0, n_sent = 0, n_runs = 0, n_words = 0;
  int unsigned stall_left = 0;
  bit long_stalls = 1;

  level_greedy_partitioner dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_word_i(in_word),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_word_o(out_word));

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Check accepted words; stall the output in bursts, mostly short, a few long
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_word(out_word);
      n_words++;
    end
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(3) == 0) begin
      out_stall <= 1'b1;
      stall_left <= (long_stalls && $urandom_range(15) == 0) ?
                    $urandom_range(8, 30) : $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned gap_len();
    int unsigned r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Present one node word and hold it until accepted
  task automatic send_node(logic [4:0] lvl, logic [31:0] cost, logic last);
    lgp_pkg::in_word_t w;
    w.node_level = lvl;
    w.node_cost = cost;
    w.last_node = last;
    in_valid <= 1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_node(w);
    n_sent++;
    if (last) n_runs++;
    repeat (gap_len()) begin
      in_valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_count(logic [4:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.part_count = v;
  endtask

  // One run of random nodes; lengths mostly short, sometimes past capacity
  task automatic send_run(int unsigned len);
    for (int i = 0; i < len; i++)
      send_node($urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(7)),
                $urandom_range(4) == 0 ? $urandom : $urandom_range(1000),
                i == len - 1);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: reset count, extremes of level and cost, zero costs
    send_node(5'd0, 32'hFFFF_FFFF, 0);
    send_node(5'd31, 32'hFFFF_FFFF, 0);
    send_node(5'd0, 32'd0, 1);
    write_count(5'd0);
    send_node(5'd3, 32'd5, 1);
    write_count(5'd31);
    send_node(5'd2, 32'd0, 0);
    send_node(5'd1, 32'd7, 0);
    send_node(5'd31, 32'd9, 1);
    write_count(5'd16);
    for (int i = 0; i < 6; i++) send_node(5'(i), 32'hAAAA_5555 >> i, i == 5);
    write_count(5'd3);
    // Overflow: a full store plus a dropped last node
    for (int i = 0; i < 49; i++) send_node(5'(i % 12), 32'(i * 3 + 1), i == 48);
    drain();
    // Random runs through several counts
    while (n_sent < 400) begin
      if ($urandom_range(3) == 0) write_count(5'($urandom));
      send_run($urandom_range(9) == 0 ? $urandom_range(40, 52) : $urandom_range(1, 10));
      if ($urandom_range(5) == 0) long_stalls = !long_stalls;
    end
    drain();
    $display("runs %0d, nodes %0d, result words %0d checked", n_runs, n_sent, n_words);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

[level_greedy_partitioner.f]
+incdir+hw/rtl
hw/rtl/lgp_pkg.sv
hw/rtl/lgp_ctrl.sv
hw/rtl/lgp_dp.sv
hw/rtl/level_greedy_partitioner.sv
hw/rtl/lgp_checker.sv
dv/testbench.sv
